[rtl/odo_pkg.sv]
// shared constants, config codes and helper functions for the odometry block
package odo_pkg;

  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_POS_FRAC_BITS   = 8;
  localparam int DEF_ANGLE_FRAC_BITS = 28;

  localparam int DIV_W   = 64;
  localparam int CORD_W  = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCH_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SPACING = 2'd2;

  localparam logic [31:0] TICK_SCALE_RST    = 32'd65536;
  localparam logic [15:0] INCH_SCALE_RST    = 16'd2580;
  localparam logic [11:0] WHEEL_SPACING_RST = 12'd177;

  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam logic signed [CORD_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;

  function automatic logic signed [CORD_W-1:0] odo_atan(input logic [4:0] i);
    logic signed [CORD_W-1:0] v;
    begin
      unique case (i)
        5'd0:  v = 34'sd843314856;
        5'd1:  v = 34'sd497837829;
        5'd2:  v = 34'sd263043836;
        5'd3:  v = 34'sd133525158;
        5'd4:  v = 34'sd67021686;
        5'd5:  v = 34'sd33543515;
        5'd6:  v = 34'sd16775850;
        5'd7:  v = 34'sd8388437;
        5'd8:  v = 34'sd4194282;
        5'd9:  v = 34'sd2097149;
        5'd10: v = 34'sd1048575;
        5'd11: v = 34'sd524287;
        5'd12: v = 34'sd262143;
        5'd13: v = 34'sd131071;
        5'd14: v = 34'sd65535;
        5'd15: v = 34'sd32767;
        5'd16: v = 34'sd16383;
        5'd17: v = 34'sd8191;
        5'd18: v = 34'sd4095;
        5'd19: v = 34'sd2047;
        5'd20: v = 34'sd1023;
        5'd21: v = 34'sd511;
        5'd22: v = 34'sd255;
        5'd23: v = 34'sd127;
        5'd24: v = 34'sd63;
        5'd25: v = 34'sd31;
        5'd26: v = 34'sd15;
        5'd27: v = 34'sd8;
        5'd28: v = 34'sd4;
        5'd29: v = 34'sd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    begin
      if (v > 65'sd2147483647) r = 32'sh7fffffff;
      else if (v < -65'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

[rtl/odo_in_if.sv]
// input channel: encoder counts, target range and home radius
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic        [15:0] target_range;
  logic        [15:0] home_radius;

  modport source (output valid, left_count, right_count, target_range, home_radius,
                  input ready);
  modport sink   (input valid, left_count, right_count, target_range, home_radius,
                  output ready);
endinterface

[rtl/odo_out_if.sv]
// result channel: pose, target point and home flag
interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [30:0] pose_angle;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic               near_home;

  modport source (output valid, pos_x, pos_y, pose_angle, target_x, target_y, near_home,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pose_angle, target_x, target_y, near_home,
                  output ready);
endinterface

[rtl/odo_div.sv]
// iterative radix-2 signed divider, truncating quotient
module odo_div
  import odo_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic signed [DIV_W-1:0] den,
  output logic                    done,
  output logic signed [DIV_W-1:0] quo
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] d_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r, qneg_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial   = {rem_r, q_r[DIV_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign rem_nxt = ge ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
  assign q_nxt   = {q_r[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= num[DIV_W-1] ? DIV_W'(-num) : num;
      d_r    <= den[DIV_W-1] ? DIV_W'(-den) : den;
      rem_r  <= '0;
      qneg_r <= num[DIV_W-1] ^ den[DIV_W-1];
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = qneg_r ? -$signed(q_r) : $signed(q_r);

endmodule

[rtl/odo_cordic.sv]
// rotation-mode cordic, one micro-rotation per cycle, sine and cosine out
module odo_cordic
  import odo_pkg::*;
#(
  parameter int STEPS = DEF_CORDIC_STEPS,
  parameter int AFRAC = DEF_ANGLE_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [31:0]       angle,
  output logic                     done,
  output logic signed [CORD_W-1:0] sin_o,
  output logic signed [CORD_W-1:0] cos_o
);

  localparam int SH = 30 - AFRAC;
  localparam int IW = $clog2(STEPS + 1);

  logic signed [CORD_W-1:0] x_r, y_r, z_r, z_in, xs, ys, xo, yo;
  logic [IW-1:0]            cnt_r;
  logic                     run_r, done_r, neg_r;

  assign z_in = CORD_W'(angle) <<< SH;
  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= GAIN_Q30;
      y_r <= '0;
      if (z_in > HALF_PI_Q30) begin
        z_r   <= z_in - PI_Q30;
        neg_r <= 1'b1;
      end else if (z_in < -HALF_PI_Q30) begin
        z_r   <= z_in + PI_Q30;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z_in;
        neg_r <= 1'b0;
      end
    end else if (run_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - odo_atan(5'(cnt_r));
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + odo_atan(5'(cnt_r));
      end
    end
  end

  assign xo    = x_r >>> SH;
  assign yo    = y_r >>> SH;
  assign done  = done_r;
  assign sin_o = neg_r ? -yo : yo;
  assign cos_o = neg_r ? -xo : xo;

endmodule

[rtl/diff_drive_odometry.sv]
// differential-drive odometry top level: sequencer, shared multiplier, divider, cordic
//
//   channel   dir   payload                                            transfer when
//   in_ch     in    left_count right_count target_range home_radius    valid && ready
//   out_ch    out   pos_x pos_y pose_angle target_x target_y near_home valid && ready
//   cfg_*     in    cfg_index cfg_wdata                                cfg_we
//
// an arc step runs the divider three times (theta and two arc quotients), a straight
// step runs it once for theta; every step also makes two cordic passes and runs the
// heading wrap
// rst_n is synchronous; it clears the pose and previous counts, resets config registers
// in_ch.ready is high only while idle; a result waits in the output register
// while out_ch.ready is low, and the sequencer holds before overwriting it
module diff_drive_odometry
  import odo_pkg::*;
#(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int POS_FRAC_BITS   = DEF_POS_FRAC_BITS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  odo_in_if.sink                in_ch,
  odo_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int P    = POS_FRAC_BITS;
  localparam int A    = ANGLE_FRAC_BITS;
  localparam int WSH  = 16 - P;
  localparam int ASH  = 30 - A;
  localparam longint PI_Q   = (PI_Q30_L + ((longint'(1) << ASH) >> 1)) >> ASH;
  localparam longint TWO_PI = 2 * PI_Q;
  // reciprocal of two pi for the heading wrap quotient estimate
  localparam int RS  = (A > P) ? A - P : 0;
  localparam int RK  = A + 33;
  localparam int QSH = RK - RS;
  localparam longint RECIP = (longint'(1) << RK) / TWO_PI;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_ML   = 6'd1;
  localparam logic [5:0] S_MR   = 6'd2;
  localparam logic [5:0] S_SR   = 6'd3;
  localparam logic [5:0] S_TH   = 6'd4;
  localparam logic [5:0] S_THW  = 6'd5;
  localparam logic [5:0] S_WR   = 6'd6;
  localparam logic [5:0] S_WQ   = 6'd7;
  localparam logic [5:0] S_WP   = 6'd8;
  localparam logic [5:0] S_WS   = 6'd9;
  localparam logic [5:0] S_WC   = 6'd10;
  localparam logic [5:0] S_C0   = 6'd11;
  localparam logic [5:0] S_C0W  = 6'd12;
  localparam logic [5:0] S_C1   = 6'd13;
  localparam logic [5:0] S_C1W  = 6'd14;
  localparam logic [5:0] S_BR   = 6'd15;
  localparam logic [5:0] S_A1   = 6'd16;
  localparam logic [5:0] S_A2   = 6'd17;
  localparam logic [5:0] S_A2W  = 6'd18;
  localparam logic [5:0] S_A3   = 6'd19;
  localparam logic [5:0] S_A4   = 6'd20;
  localparam logic [5:0] S_A4W  = 6'd21;
  localparam logic [5:0] S_S1   = 6'd22;
  localparam logic [5:0] S_S2   = 6'd23;
  localparam logic [5:0] S_S3   = 6'd24;
  localparam logic [5:0] S_UPD  = 6'd25;
  localparam logic [5:0] S_T1   = 6'd26;
  localparam logic [5:0] S_T2   = 6'd27;
  localparam logic [5:0] S_T3   = 6'd28;
  localparam logic [5:0] S_T4   = 6'd29;
  localparam logic [5:0] S_T5   = 6'd30;
  localparam logic [5:0] S_T6   = 6'd31;
  localparam logic [5:0] S_T7   = 6'd32;
  localparam logic [5:0] S_T8   = 6'd33;

  logic [5:0] state_r, state_nxt;

  // config
  logic [31:0] tick_r;
  logic [15:0] inch_r;
  logic [11:0] ws_r;

  // architectural state
  logic [31:0]        prev_l_r, prev_rt_r;
  logic signed [30:0] ang_r;
  logic signed [31:0] x_r, y_r;

  // work registers
  logic signed [31:0]       dlt_l_r, dlt_r_r, dl_r, dr_r;
  logic [15:0]              rng_r, rad_r;
  logic [63:0]              p_r;
  logic signed [63:0]       theta_r, dx_r, dy_r;
  logic signed [30:0]       h1_r;
  logic signed [CORD_W-1:0] s0_r, c0_r, s1_r, c1_r;
  logic signed [32:0]       ds_r, dc_r;
  logic signed [33:0]       tx_r, ty_r;
  logic [63:0]              d2_r;
  logic [63:0]              wmag_r;
  logic                     wneg_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] o_x_r, o_y_r, o_tx_r, o_ty_r;
  logic signed [30:0] o_ang_r;
  logic               o_near_r;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  logic               mul_en;

  // divider and cordic hookup
  logic                     div_start, div_done;
  logic signed [63:0]       div_num, div_den, div_quo;
  logic                     cor_start, cor_done;
  logic signed [31:0]       cor_angle;
  logic signed [CORD_W-1:0] cor_sin, cor_cos;

  logic [11:0]        ws_eff;
  logic signed [63:0] ws_den, th_num, wr_r1, wr_h, p_s, wsum;
  logic signed [33:0] half_q, rng_q;
  logic signed [32:0] rad_q, sum_lr;
  logic               in_xfer;

  assign ws_eff  = (ws_r == 12'd0) ? 12'd1 : ws_r;
  assign ws_den  = 64'(ws_eff) << P;
  assign half_q  = 34'(ws_den >>> 1);
  assign th_num  = (64'(dr_r) - 64'(dl_r)) <<< A;
  assign rng_q   = 34'(rng_r) << P;
  assign rad_q   = 33'(rad_r) << P;
  assign sum_lr  = 33'(dl_r) + 33'(dr_r);
  assign p_s     = $signed(p_r);
  assign wsum    = 64'(ang_r) + theta_r;
  assign wr_r1   = (wneg_r && wmag_r != 64'd0) ? 64'(TWO_PI) - $signed(wmag_r)
                                                : $signed(wmag_r);
  assign wr_h    = (wr_r1 >= 64'(PI_Q)) ? wr_r1 - 64'(TWO_PI) : wr_r1;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_r)
      S_ML: begin mul_a = 34'(dlt_l_r); mul_b = {1'b0, tick_r}; end
      S_MR: begin mul_a = 34'(dlt_r_r); mul_b = {1'b0, tick_r}; end
      S_WQ: begin mul_a = 34'(wmag_r >> RS); mul_b = 33'(RECIP); end
      S_WP: begin mul_a = 34'(p_r >> QSH);   mul_b = 33'(TWO_PI); end
      S_A1: begin mul_a = 34'(dr_r);    mul_b = ds_r; end
      S_A2: begin mul_a = half_q;       mul_b = ds_r; end
      S_A3: begin mul_a = 34'(dr_r);    mul_b = dc_r; end
      S_A4: begin mul_a = half_q;       mul_b = dc_r; end
      S_S1: begin mul_a = 34'(ds_r);    mul_b = 33'(c0_r); end
      S_S2: begin mul_a = 34'(ds_r);    mul_b = 33'(s0_r); end
      S_T1: begin mul_a = rng_q;        mul_b = 33'(c1_r); end
      S_T2: begin mul_a = rng_q;        mul_b = 33'(s1_r); end
      S_T3: begin mul_a = tx_r;         mul_b = 33'(inch_r); end
      S_T4: begin mul_a = ty_r;         mul_b = 33'(inch_r); end
      S_T5: begin mul_a = 34'(x_r);     mul_b = 33'(x_r); end
      S_T6: begin mul_a = 34'(y_r);     mul_b = 33'(y_r); end
      S_T7: begin mul_a = 34'(rad_q);   mul_b = rad_q; end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = th_num;
    div_den   = ws_den;
    unique case (state_r)
      S_TH: div_start = 1'b1;
      S_A2, S_A4: begin
        div_start = 1'b1;
        div_num   = p_s;
        div_den   = theta_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign cor_start = (state_r == S_C0) || (state_r == S_C1);
  assign cor_angle = (state_r == S_C1) ? 32'(h1_r) : 32'(ang_r);

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  odo_cordic #(
    .STEPS (CORDIC_STEPS),
    .AFRAC (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_ML;
      S_ML:   state_nxt = S_MR;
      S_MR:   state_nxt = S_SR;
      S_SR:   state_nxt = S_TH;
      S_TH:   state_nxt = S_THW;
      S_THW:  if (div_done) state_nxt = S_WR;
      S_WR:   state_nxt = S_WQ;
      S_WQ:   state_nxt = S_WP;
      S_WP:   state_nxt = S_WS;
      S_WS:   state_nxt = S_WC;
      S_WC:   if (wmag_r < 64'(TWO_PI)) state_nxt = S_C0;
      S_C0:   state_nxt = S_C0W;
      S_C0W:  if (cor_done) state_nxt = S_C1;
      S_C1:   state_nxt = S_C1W;
      S_C1W:  if (cor_done) state_nxt = S_BR;
      S_BR:   state_nxt = (theta_r != 0) ? S_A1 : S_S1;
      S_A1:   state_nxt = S_A2;
      S_A2:   state_nxt = S_A2W;
      S_A2W:  if (div_done) state_nxt = S_A3;
      S_A3:   state_nxt = S_A4;
      S_A4:   state_nxt = S_A4W;
      S_A4W:  if (div_done) state_nxt = S_UPD;
      S_S1:   state_nxt = S_S2;
      S_S2:   state_nxt = S_S3;
      S_S3:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_T1;
      S_T1:   state_nxt = S_T2;
      S_T2:   state_nxt = S_T3;
      S_T3:   state_nxt = S_T4;
      S_T4:   state_nxt = S_T5;
      S_T5:   state_nxt = S_T6;
      S_T6:   state_nxt = S_T7;
      S_T7:   state_nxt = S_T8;
      S_T8:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= TICK_SCALE_RST;
      inch_r      <= INCH_SCALE_RST;
      ws_r        <= WHEEL_SPACING_RST;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
      ang_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICK_SCALE:    tick_r <= cfg_wdata;
          CFG_INCH_SCALE:    inch_r <= cfg_wdata[15:0];
          CFG_WHEEL_SPACING: ws_r   <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        prev_l_r  <= in_ch.left_count;
        prev_rt_r <= in_ch.right_count;
      end
      if (state_r == S_UPD) begin
        x_r   <= sat32(65'(x_r) + 65'(dx_r));
        y_r   <= sat32(65'(y_r) + 65'(dy_r));
        ang_r <= h1_r;
      end
      if (state_r == S_T8 && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mul_en) p_r <= prod[63:0];
    if (in_xfer) begin
      dlt_l_r <= $signed(in_ch.left_count - prev_l_r);
      dlt_r_r <= $signed(in_ch.right_count - prev_rt_r);
      rng_r   <= in_ch.target_range;
      rad_r   <= in_ch.home_radius;
    end
    unique case (state_r)
      S_MR:  dl_r <= sat32(65'(p_s >>> WSH));
      S_SR:  dr_r <= sat32(65'(p_s >>> WSH));
      S_THW: if (div_done) theta_r <= div_quo;
      S_WR: begin
        wmag_r <= wsum[63] ? 64'(-wsum) : 64'(wsum);
        wneg_r <= wsum[63];
      end
      S_WS:  wmag_r <= wmag_r - p_r;
      S_WC: begin
        if (wmag_r >= 64'(TWO_PI)) wmag_r <= wmag_r - 64'(TWO_PI);
        else h1_r <= 31'(wr_h);
      end
      S_C0W: if (cor_done) begin s0_r <= cor_sin; c0_r <= cor_cos; end
      S_C1W: if (cor_done) begin s1_r <= cor_sin; c1_r <= cor_cos; end
      S_BR: begin
        if (theta_r != 0) begin
          ds_r <= 33'(s1_r - s0_r);
          dc_r <= 33'(c0_r - c1_r);
        end else begin
          ds_r <= sum_lr >>> 1;
        end
      end
      S_A2W: if (div_done) dx_r <= div_quo - (p_s >>> A);
      S_A4W: if (div_done) dy_r <= div_quo - (p_s >>> A);
      S_S2:  dx_r <= p_s >>> A;
      S_S3:  dy_r <= p_s >>> A;
      S_T2:  tx_r <= 34'(x_r) + 34'(p_s >>> A);
      S_T3:  ty_r <= 34'(y_r) + 34'(p_s >>> A);
      S_T4:  tx_r <= 34'(sat32(65'(p_s >>> 16)));
      S_T5:  ty_r <= 34'(sat32(65'(p_s >>> 16)));
      S_T6:  d2_r <= p_r;
      S_T7:  d2_r <= d2_r + p_r;
      S_T8: begin
        if (!out_valid_r || out_ch.ready) begin
          o_x_r    <= x_r;
          o_y_r    <= y_r;
          o_ang_r  <= ang_r;
          o_tx_r   <= tx_r[31:0];
          o_ty_r   <= ty_r[31:0];
          o_near_r <= d2_r < p_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pos_x      = o_x_r;
  assign out_ch.pos_y      = o_y_r;
  assign out_ch.pose_angle = o_ang_r;
  assign out_ch.target_x   = o_tx_r;
  assign out_ch.target_y   = o_ty_r;
  assign out_ch.near_home  = o_near_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (64'(o_ang_r) >= -64'(PI_Q)) && (64'(o_ang_r) < 64'(PI_Q)))
    else $error("heading outside wrap range");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_T8))
    else $error("result raised outside final step");

  a_single_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_start && cor_start))
    else $error("divider and cordic started together");

endmodule

[tb/tb_top.sv]
// self-checking testbench for diff_drive_odometry: directed and random encoder traffic
module tb_top;
  import odo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 30000;
  localparam int LONG_HOLD  = 1500;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [30:0] pose_angle;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic               near_home;
  } pose_t;

  class pose_tracker;
    logic [31:0] tick_scale, inch_scale, wheel_spacing;
    logic [31:0] last_left, last_right;
    longint heading, x_pos, y_pos;
    pose_t pose_q[$];
    int errors;
    longint atan_tab[16];

    function new();
      atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767};
      errors = 0;
      clear();
    endfunction

    function void clear();
      tick_scale = TICK_SCALE_RST;
      inch_scale = 32'(INCH_SCALE_RST);
      wheel_spacing = 32'(WHEEL_SPACING_RST);
      last_left = '0;
      last_right = '0;
      heading = 0;
      x_pos = 0;
      y_pos = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_TICK_SCALE:    tick_scale = data;
        CFG_INCH_SCALE:    inch_scale = {16'd0, data[15:0]};
        CFG_WHEEL_SPACING: wheel_spacing = {20'd0, data[11:0]};
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint wheel_travel(logic [31:0] cur, logic [31:0] prev);
      logic signed [31:0] delta;
      longint d, ts;
      delta = cur - prev;
      d = delta;
      ts = longint'({32'd0, tick_scale});
      return clamp32((d * ts) >>> 8);
    endfunction

    function longint wrap_pi(longint a);
      longint p, m, r;
      p = 64'sd843314857;
      m = 2 * p;
      r = a % m;
      if (r < 0) r += m;
      if (r >= p) r -= m;
      return r;
    endfunction

    function void sin_cos(longint ang, output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit flip;
      z = ang * 4;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426;
        flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      x = x >>> 2;
      y = y >>> 2;
      if (flip) begin
        x = -x;
        y = -y;
      end
      s = y;
      c = x;
    endfunction

    function void note_counts(logic [31:0] lc, logic [31:0] rc, logic [15:0] range,
                              logic [15:0] radius);
      longint ws, dl, dr, theta, h1, s0, c0, s1, c1, dx, dy, half, ds, dc, d, rg, tx, ty;
      longint unsigned r2, d2, rad;
      pose_t p;
      ws = (wheel_spacing == 0) ? 1 : longint'({32'd0, wheel_spacing});
      dl = wheel_travel(lc, last_left);
      dr = wheel_travel(rc, last_right);
      last_left = lc;
      last_right = rc;
      theta = ((dr - dl) * 64'sd268435456) / (ws * 256);
      h1 = wrap_pi(heading + theta);
      sin_cos(heading, s0, c0);
      sin_cos(h1, s1, c1);
      if (theta != 0) begin
        half = (ws * 256) / 2;
        ds = s1 - s0;
        dc = c0 - c1;
        dx = (dr * ds) / theta - ((half * ds) >>> 28);
        dy = (dr * dc) / theta - ((half * dc) >>> 28);
      end else begin
        d = (dl + dr) >>> 1;
        dx = (d * c0) >>> 28;
        dy = (d * s0) >>> 28;
      end
      x_pos = clamp32(x_pos + dx);
      y_pos = clamp32(y_pos + dy);
      heading = h1;
      rg = longint'({48'd0, range}) * 256;
      tx = x_pos + ((rg * c1) >>> 28);
      ty = y_pos + ((rg * s1) >>> 28);
      tx = clamp32((tx * longint'({32'd0, inch_scale})) >>> 16);
      ty = clamp32((ty * longint'({32'd0, inch_scale})) >>> 16);
      rad = {40'd0, radius, 8'd0};
      r2 = rad * rad;
      d2 = longint'(x_pos * x_pos) + longint'(y_pos * y_pos);
      p.pos_x = x_pos[31:0];
      p.pos_y = y_pos[31:0];
      p.pose_angle = heading[30:0];
      p.target_x = tx[31:0];
      p.target_y = ty[31:0];
      p.near_home = (d2 < r2);
      pose_q.push_back(p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (pose_q.size() == 0) begin
        report("unexpected result", 32'(got.pos_x), 32'd0);
        return;
      end
      want = pose_q.pop_front();
      if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
      if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
      if (got.pose_angle !== want.pose_angle)
        report("pose_angle", 32'(got.pose_angle), 32'(want.pose_angle));
      if (got.target_x !== want.target_x) report("target_x", got.target_x, want.target_x);
      if (got.target_y !== want.target_y) report("target_y", got.target_y, want.target_y);
      if (got.near_home !== want.near_home)
        report("near_home", 32'(got.near_home), 32'(want.near_home));
    endtask
  endclass

  logic clk = 0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  odo_in_if in_ch();
  odo_out_if out_ch();

  pose_tracker tracker = new();
  int idle_cycles = 0;
  bit hold_req = 0;
  logic [31:0] cur_left = 0, cur_right = 0;

  diff_drive_odometry u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // transfer monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    pose_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_counts(in_ch.left_count, in_ch.right_count, in_ch.target_range,
                            in_ch.home_radius);
      if (out_ch.valid && out_ch.ready) begin
        got.pos_x = out_ch.pos_x;
        got.pos_y = out_ch.pos_y;
        got.pose_angle = out_ch.pose_angle;
        got.target_x = out_ch.target_x;
        got.target_y = out_ch.target_y;
        got.near_home = out_ch.near_home;
        tracker.check_pose(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[diff_drive_odometry] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, quiet stretches and one long hold
  initial begin
    int quiet;
    out_ch.ready <= 1'b0;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
        out_ch.ready <= 1'b1;
      end else if (quiet > 0) begin
        quiet--;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        quiet = $urandom_range(200, 2000);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(50, 400)) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 65);
      end
    end
  end

  task automatic write_regs(logic [31:0] ts, logic [31:0] is, logic [31:0] ws);
    cfg_we <= 1'b1; cfg_index <= CFG_TICK_SCALE; cfg_wdata <= ts;
    @(posedge clk);
    cfg_index <= CFG_INCH_SCALE; cfg_wdata <= is;
    @(posedge clk);
    cfg_index <= CFG_WHEEL_SPACING; cfg_wdata <= ws;
    @(posedge clk);
    cfg_index <= CFG_UNUSED; cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(CFG_TICK_SCALE, ts);
    tracker.write_reg(CFG_INCH_SCALE, is);
    tracker.write_reg(CFG_WHEEL_SPACING, ws);
    @(posedge clk);
  endtask

  task automatic drain();
    while (tracker.pose_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_counts(logic [31:0] l, logic [31:0] r, logic [15:0] rg,
                             logic [15:0] rad, int gap);
    in_ch.valid <= 1'b1;
    in_ch.left_count <= l;
    in_ch.right_count <= r;
    in_ch.target_range <= rg;
    in_ch.home_radius <= rad;
    cur_left = l;
    cur_right = r;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit busy);
    int k;
    if (busy) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 5);
    return $urandom_range(50, 600);
  endfunction

  task automatic random_burst(int n, bit with_hold);
    logic [31:0] l, r;
    logic [15:0] rg, rad;
    int k, busy;
    busy = 0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        l = cur_left + 32'($signed($urandom_range(0, 4000)) - 2000);
        r = cur_right + 32'($signed($urandom_range(0, 4000)) - 2000);
      end else if (k < 85) begin
        l = cur_left + 32'($signed($urandom_range(0, 6000)) - 3000);
        r = cur_right + (l - cur_left);
      end else if (k < 92) begin
        l = cur_left + $urandom;
        r = cur_right + 32'($signed($urandom_range(0, 200)) - 100);
      end else begin
        l = $urandom;
        r = $urandom;
      end
      k = $urandom_range(0, 9);
      rg = (k == 0) ? 16'hffff : (k == 1) ? 16'd0 : 16'($urandom);
      k = $urandom_range(0, 9);
      rad = (k < 3) ? 16'hffff : (k == 3) ? 16'd0 : 16'($urandom);
      if (with_hold && i == 10) hold_req = 1;
      if (busy > 0) busy--;
      else if ($urandom_range(0, 99) < 5) busy = $urandom_range(10, 40);
      send_counts(l, r, rg, rad, pick_gap(busy > 0));
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TICK_SCALE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.left_count <= '0;
    in_ch.right_count <= '0;
    in_ch.target_range <= '0;
    in_ch.home_radius <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero step, straight, turns, heading wrap, count extremes
    send_counts(0, 0, 0, 0, 0);
    send_counts(1000, 1000, 100, 10, 0);
    send_counts(1500, 2000, 16'hffff, 16'hffff, 2);
    send_counts(2500, 1500, 500, 0, 0);
    send_counts(2500, 30000, 300, 1000, 0);
    send_counts(2500, 60000, 300, 1000, 0);
    send_counts(-100000, -100000, 65535, 20, 0);
    send_counts(32'h7fffffff, 32'h7fffffff, 1, 65535, 0);
    send_counts(32'h80000000, 32'h80000000, 0, 0, 0);
    send_counts(32'h80000000, 32'h7fffffff, 1234, 1, 3);
    send_counts(0, 0, 16'hffff, 16'hffff, 0);
    send_counts(5, 5, 0, 16'hffff, 0);
    in_ch.valid <= 1'b0;
    drain();

    // extremes of the scale registers, and a zero spacing
    write_regs(32'd1, 32'd1, 32'd1);
    send_counts(cur_left + 700, cur_right + 900, 16'hffff, 16'hffff, 0);
    send_counts(cur_left + 32'h40000000, cur_right - 32'h40000000, 100, 100, 0);
    in_ch.valid <= 1'b0;
    drain();
    write_regs(32'hffffffff, 32'd65535, 32'd4095);
    send_counts(cur_left + 1, cur_right + 2, 16'hffff, 16'hffff, 0);
    send_counts(cur_left + 32'h7fffffff, cur_right + 32'h80000000, 16'hffff, 0, 0);
    send_counts(cur_left - 3, cur_right + 3, 7, 7, 0);
    in_ch.valid <= 1'b0;
    drain();
    write_regs(32'h00020000, 32'd2580, 32'd0);
    send_counts(cur_left + 10, cur_right + 12, 50, 50, 0);
    send_counts(cur_left + 40, cur_right + 40, 50, 65535, 0);
    in_ch.valid <= 1'b0;
    drain();

    write_regs(32'd65536, 32'd2580, 32'd177);
    random_burst(250, 1);
    write_regs(32'h00008000, 32'd65535, 32'd4095);
    random_burst(150, 0);
    write_regs(32'd1, 32'd1, 32'd1);
    random_burst(100, 0);
    write_regs(32'hffffffff, 32'd1, 32'd0);
    random_burst(80, 0);
    write_regs($urandom, $urandom_range(1, 65535), $urandom_range(1, 4095));
    random_burst(100, 0);
    write_regs($urandom_range(1000, 300000), $urandom_range(1, 65535),
               $urandom_range(50, 400));
    random_burst(150, 0);

    repeat (400) @(posedge clk);
    if (tracker.errors == 0 && tracker.pose_q.size() == 0) begin
      $display("[diff_drive_odometry] OK");
    end else begin
      $display("[diff_drive_odometry] ERROR");
    end
    $finish;
  end

endmodule
